### design/trm_pkg.sv
`default_nettype none
package trm_pkg;

	localparam int WORD_W = 16;
	localparam int ADDR_W = 12;
	localparam int RIDX_W = 2;
	localparam int NREGS = 4;
	localparam int IMM_W = 10;

	localparam logic [1:0] MODE_RESET = 2'd0;
	localparam logic [1:0] MODE_LOAD = 2'd1;
	localparam logic [1:0] MODE_EXEC = 2'd2;

	localparam logic [1:0] ST_OK = 2'd0;
	localparam logic [1:0] ST_HALT = 2'd1;
	localparam logic [1:0] ST_DIV0 = 2'd2;
	localparam logic [1:0] ST_STOPPED = 2'd3;

	typedef enum logic [3:0] {
		OP_ADD = 4'd0,
		OP_SUB = 4'd1,
		OP_MULT = 4'd2,
		OP_DIV = 4'd3,
		OP_MOVI = 4'd4,
		OP_LOAD = 4'd5,
		OP_STORE = 4'd6,
		OP_PUSH = 4'd7,
		OP_POP = 4'd8,
		OP_AND = 4'd9,
		OP_OR = 4'd10,
		OP_XOR = 4'd11,
		OP_CMP = 4'd12,
		OP_JMP = 4'd13,
		OP_JZ = 4'd14,
		OP_HALT = 4'd15
	} op_t;

	typedef enum logic [3:0] {
		S_IDLE = 4'b0001,
		S_FETCH = 4'b0010,
		S_EXEC = 4'b0100,
		S_DIV = 4'b1000
	} state_t;

	typedef logic [WORD_W-1:0] word_t;
	typedef logic [ADDR_W-1:0] addr_t;

endpackage
`default_nettype wire

### design/trm_cmd_if.sv
`default_nettype none
interface trm_cmd_if;
	logic valid;
	logic ready;
	logic [1:0] mode;
	trm_pkg::addr_t load_addr;
	trm_pkg::word_t load_data;

	modport source (output valid, output mode, output load_addr, output load_data, input ready);
	modport sink (input valid, input mode, input load_addr, input load_data, output ready);
endinterface
`default_nettype wire

### design/trm_rsp_if.sv
`default_nettype none
interface trm_rsp_if;
	logic valid;
	logic ready;
	logic [1:0] status;
	trm_pkg::addr_t next_pc;
	logic reg_written;
	logic [trm_pkg::RIDX_W-1:0] dest_index;
	trm_pkg::word_t dest_value;
	logic flag_out;

	modport source (output valid, output status, output next_pc, output reg_written,
		output dest_index, output dest_value, output flag_out, input ready);
	modport sink (input valid, input status, input next_pc, input reg_written,
		input dest_index, input dest_value, input flag_out, output ready);
endinterface
`default_nettype wire

### design/tiny_register_machine_core_top.sv
// Small 16-bit register machine with four registers, a zero flag, a 12-bit pc and stack
// pointer and one shared word memory of MEM_DEPTH words. Reset, load and ignored items
// (mode 0, mode 1, mode 3, or execute while stopped) take one cycle: the result is
// registered the cycle after the item is accepted. An executed instruction goes through
// fetch from the word memory, register file and data memory read, then execute and write
// back; a division that is not by zero also runs the bit-serial divider, one quotient bit
// per cycle. A new item is taken once the core is idle and the previous result has been
// taken or is being taken. Words of the memory that were never loaded read back as
// undefined.
`default_nettype none
module tiny_register_machine_core_top #(
	parameter int MEM_DEPTH = 4096,
	parameter int CODE_BASE = 0,
	parameter int DATA_BASE = 2048,
	parameter int STACK_BASE = 4096
) (
	input wire logic clk,
	input wire logic arst_n,
	trm_cmd_if.sink cmd,
	trm_rsp_if.source rsp
);
	import trm_pkg::*;

	localparam int MEM_AW = $clog2(MEM_DEPTH);
	localparam int DIV_CW = $clog2(WORD_W);
	localparam addr_t PC_RST = ADDR_W'(CODE_BASE);
	localparam addr_t SP_RST = ADDR_W'(STACK_BASE - 1);
	localparam addr_t DATA_A = ADDR_W'(DATA_BASE);
	localparam logic [ADDR_W:0] MEM_LIMIT = (ADDR_W+1)'(MEM_DEPTH);

	state_t state_q;
	addr_t pc_q, sp_q;
	logic flag_q, stopped_q;
	logic [NREGS-1:0] rf_vld_q;

	word_t mem [MEM_DEPTH];
	word_t mem_rd_q;
	logic mem_ok_q;
	word_t rf_mem [NREGS];
	word_t rf_rd0_q, rf_rd1_q;
	logic rf_ok0_q, rf_ok1_q;
	word_t ins_q;

	word_t div_rem_q, div_quo_q, div_den_q;
	logic [DIV_CW-1:0] div_cnt_q;

	logic out_vld_q;
	logic [1:0] out_status_q;
	addr_t out_pc_q;
	logic out_wr_q;
	logic [RIDX_W-1:0] out_idx_q;
	word_t out_val_q;
	logic out_flag_q;

	logic cmd_acc, out_free, exec_go;
	logic load_ok;

	// fetch stage decode
	word_t fetched;
	op_t f_op;
	addr_t data_addr;
	addr_t mem_ra;
	logic mem_re;
	logic [RIDX_W-1:0] rf_ra0, rf_ra1;

	// execute stage
	op_t op;
	logic [RIDX_W-1:0] e_a;
	addr_t e_target;
	word_t v0, v1, mdata;
	logic [2*WORD_W-1:0] prod_full;
	word_t alu_res, wb_res;
	logic alu_wr, stop_n, flag_n, div_start, commit;
	logic [1:0] status_n;
	addr_t npc, sp_n;
	logic mwe_x;
	addr_t mwa_x;
	logic mem_we;
	addr_t mem_wa;
	word_t mem_wd;
	logic rf_we;

	// divider step
	logic [WORD_W:0] div_shift, div_diff;
	logic div_ge;
	word_t div_rem_nxt, div_quo_nxt;
	logic div_last;

	assign cmd_acc = cmd.valid && cmd.ready;
	assign out_free = !out_vld_q || rsp.ready;
	assign cmd.ready = (state_q == S_IDLE) && out_free;
	assign exec_go = cmd_acc && (cmd.mode == MODE_EXEC) && !stopped_q;
	assign load_ok = {1'b0, cmd.load_addr} < MEM_LIMIT;

	assign fetched = mem_ok_q ? mem_rd_q : '0;
	assign f_op = op_t'(fetched[WORD_W-1 -: 4]);
	assign data_addr = (f_op == OP_POP) ? sp_q : DATA_A + ADDR_W'(fetched[IMM_W-1:0]);
	assign mem_ra = (state_q == S_FETCH) ? data_addr : pc_q;
	assign mem_re = (state_q == S_IDLE) || (state_q == S_FETCH);
	assign rf_ra0 = (f_op inside {OP_CMP, OP_STORE, OP_PUSH}) ? fetched[11:10] : fetched[9:8];
	assign rf_ra1 = (f_op == OP_CMP) ? fetched[9:8] : fetched[7:6];

	assign op = op_t'(ins_q[WORD_W-1 -: 4]);
	assign e_a = ins_q[11:10];
	assign e_target = ins_q[ADDR_W-1:0];
	assign v0 = rf_ok0_q ? rf_rd0_q : '0;
	assign v1 = rf_ok1_q ? rf_rd1_q : '0;
	assign mdata = mem_ok_q ? mem_rd_q : '0;
	assign prod_full = (2*WORD_W)'(v0) * (2*WORD_W)'(v1);

	always_comb begin
		alu_res = '0;
		alu_wr = 1'b0;
		stop_n = 1'b0;
		flag_n = flag_q;
		status_n = ST_OK;
		npc = pc_q + 1'b1;
		sp_n = sp_q;
		mwe_x = 1'b0;
		mwa_x = DATA_A + ADDR_W'(ins_q[IMM_W-1:0]);
		div_start = 1'b0;
		case (op)
			OP_ADD: begin alu_res = v0 + v1; alu_wr = 1'b1; end
			OP_SUB: begin alu_res = v0 - v1; alu_wr = 1'b1; end
			OP_MULT: begin alu_res = prod_full[WORD_W-1:0]; alu_wr = 1'b1; end
			OP_DIV: begin
				if (v1 == '0) begin
					status_n = ST_DIV0;
					stop_n = 1'b1;
				end else begin
					div_start = 1'b1;
					alu_wr = 1'b1;
				end
			end
			OP_MOVI: begin alu_res = WORD_W'(ins_q[IMM_W-1:0]); alu_wr = 1'b1; end
			OP_LOAD: begin alu_res = mdata; alu_wr = 1'b1; end
			OP_STORE: mwe_x = 1'b1;
			OP_PUSH: begin
				sp_n = sp_q - 1'b1;
				mwa_x = sp_q - 1'b1;
				mwe_x = 1'b1;
			end
			OP_POP: begin
				alu_res = mdata;
				alu_wr = 1'b1;
				sp_n = sp_q + 1'b1;
			end
			OP_AND: begin alu_res = v0 & v1; alu_wr = 1'b1; end
			OP_OR: begin alu_res = v0 | v1; alu_wr = 1'b1; end
			OP_XOR: begin alu_res = v0 ^ v1; alu_wr = 1'b1; end
			OP_CMP: flag_n = (v0 == v1);
			OP_JMP: npc = e_target;
			OP_JZ: begin
				if (flag_q) begin
					npc = e_target;
				end
			end
			OP_HALT: begin status_n = ST_HALT; stop_n = 1'b1; end
			default: begin status_n = ST_HALT; stop_n = 1'b1; end
		endcase
	end

	assign div_shift = {div_rem_q, div_quo_q[WORD_W-1]};
	assign div_diff = div_shift - {1'b0, div_den_q};
	assign div_ge = !div_diff[WORD_W];
	assign div_rem_nxt = div_ge ? div_diff[WORD_W-1:0] : div_shift[WORD_W-1:0];
	assign div_quo_nxt = {div_quo_q[WORD_W-2:0], div_ge};
	assign div_last = div_cnt_q == DIV_CW'(WORD_W - 1);

	assign commit = ((state_q == S_EXEC) && !div_start) || ((state_q == S_DIV) && div_last);
	assign wb_res = (state_q == S_DIV) ? div_quo_nxt : alu_res;
	assign rf_we = commit && alu_wr;

	always_comb begin
		mem_we = 1'b0;
		mem_wa = cmd.load_addr;
		mem_wd = cmd.load_data;
		if (cmd_acc && cmd.mode == MODE_LOAD) begin
			mem_we = load_ok;
		end else if (commit && mwe_x) begin
			mem_we = {1'b0, mwa_x} < MEM_LIMIT;
			mem_wa = mwa_x;
			mem_wd = v0;
		end
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[mem_wa[MEM_AW-1:0]] <= mem_wd;
		end
		if (mem_re) begin
			mem_rd_q <= mem[mem_ra[MEM_AW-1:0]];
			mem_ok_q <= {1'b0, mem_ra} < MEM_LIMIT;
		end
	end

	always_ff @(posedge clk) begin
		if (rf_we) begin
			rf_mem[e_a] <= wb_res;
		end
		if (state_q == S_FETCH) begin
			rf_rd0_q <= rf_mem[rf_ra0];
			rf_rd1_q <= rf_mem[rf_ra1];
			rf_ok0_q <= rf_vld_q[rf_ra0];
			rf_ok1_q <= rf_vld_q[rf_ra1];
			ins_q <= fetched;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_EXEC) begin
			div_rem_q <= '0;
			div_quo_q <= v0;
			div_den_q <= v1;
			div_cnt_q <= '0;
		end else if (state_q == S_DIV) begin
			div_rem_q <= div_rem_nxt;
			div_quo_q <= div_quo_nxt;
			div_cnt_q <= div_cnt_q + 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			pc_q <= PC_RST;
			sp_q <= SP_RST;
			flag_q <= 1'b0;
			stopped_q <= 1'b0;
			rf_vld_q <= '0;
		end else begin
			if (cmd_acc && cmd.mode == MODE_RESET) begin
				pc_q <= PC_RST;
				sp_q <= SP_RST;
				flag_q <= 1'b0;
				stopped_q <= 1'b0;
				rf_vld_q <= '0;
			end
			if (commit) begin
				pc_q <= npc;
				sp_q <= sp_n;
				flag_q <= flag_n;
				if (stop_n) begin
					stopped_q <= 1'b1;
				end
				if (alu_wr) begin
					rf_vld_q[e_a] <= 1'b1;
				end
			end
			case (state_q)
				S_IDLE: begin
					if (exec_go) begin
						state_q <= S_FETCH;
					end
				end
				S_FETCH: state_q <= S_EXEC;
				S_EXEC: state_q <= div_start ? S_DIV : S_IDLE;
				S_DIV: begin
					if (div_last) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if ((cmd_acc && !exec_go) || commit) begin
			out_vld_q <= 1'b1;
		end else if (rsp.ready) begin
			out_vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd_acc && !exec_go) begin
			out_status_q <= (cmd.mode == MODE_EXEC) ? ST_STOPPED : ST_OK;
			out_pc_q <= (cmd.mode == MODE_RESET) ? PC_RST : pc_q;
			out_flag_q <= (cmd.mode == MODE_RESET) ? 1'b0 : flag_q;
			out_wr_q <= 1'b0;
			out_idx_q <= '0;
			out_val_q <= '0;
		end else if (commit) begin
			out_status_q <= status_n;
			out_pc_q <= npc;
			out_flag_q <= flag_n;
			out_wr_q <= alu_wr;
			out_idx_q <= alu_wr ? e_a : '0;
			out_val_q <= alu_wr ? wb_res : '0;
		end
	end

	assign rsp.valid = out_vld_q;
	assign rsp.status = out_status_q;
	assign rsp.next_pc = out_pc_q;
	assign rsp.reg_written = out_wr_q;
	assign rsp.dest_index = out_idx_q;
	assign rsp.dest_value = out_val_q;
	assign rsp.flag_out = out_flag_q;

	a_exec_enters_fetch: assert property (@(posedge clk) disable iff (!arst_n)
		exec_go |=> state_q == S_FETCH)
		else $error("accepted instruction did not enter fetch");

	a_no_write_when_stopped: assert property (@(posedge clk) disable iff (!arst_n)
		stopped_q |-> !rf_we)
		else $error("register write while stopped");

	a_write_only_ok: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid && rsp.reg_written |-> rsp.status == ST_OK)
		else $error("register written with error status");

	a_div_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_DIV |-> div_den_q != '0)
		else $error("divider running on zero divisor");

	a_commit_slot_free: assert property (@(posedge clk) disable iff (!arst_n)
		commit |-> !out_vld_q)
		else $error("result committed over a pending item");

endmodule
`default_nettype wire
